// File: rtl/core/ktt_pkg.sv
// shared types and constants of the k-th largest tracker
`default_nettype none

package ktt_pkg;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RANK_W = 7;

  // default depth of the cell chain
  localparam int unsigned MAX_RANK_DEF = 64;

  // per-transfer command broadcast to every cell
  typedef struct packed {
    logic add;   // insert the sample at its sorted place
    logic repl;  // drop the smallest value and insert the sample
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/ktt_cell.sv
// one cell of the sorted chain: holds one kept value, ascending from cell 0
`default_nettype none

module ktt_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire                                  clk_i,
  input  wire ktt_pkg::cell_ctrl_t             ctrl_i,
  input  wire [CNT_W-1:0]                      count_i,
  input  wire signed [ktt_pkg::DATA_W-1:0]     sample_i,
  input  wire signed [ktt_pkg::DATA_W-1:0]     prev_value_i,
  input  wire                                  prev_gt_i,
  input  wire signed [ktt_pkg::DATA_W-1:0]     next_value_i,
  input  wire                                  next_lt_i,
  output logic signed [ktt_pkg::DATA_W-1:0]    value_o,
  output logic signed [ktt_pkg::DATA_W-1:0]    value_d_o,
  output logic                                 gt_o,
  output logic                                 lt_o
);
  import ktt_pkg::*;

  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     own_valid;

  // cell holds a kept value when it lies below the fill level
  assign own_valid = (count_i > CNT_W'(INDEX));

  // an empty cell counts as larger than any sample
  assign gt_o = !own_valid || (sample_i < value_q);
  assign lt_o = own_valid && (value_q < sample_i);

  // insert shifts larger values up, replace shifts smaller values down
  always_comb begin
    value_d = value_q;
    if (ctrl_i.add) begin
      if (gt_o) begin
        value_d = prev_gt_i ? prev_value_i : sample_i;
      end
    end else if (ctrl_i.repl) begin
      if (lt_o) begin
        value_d = next_lt_i ? next_value_i : sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign value_d_o = value_d;

endmodule

`default_nettype wire

// File: rtl/core/kth_largest_tracker_unit.sv
// top level of the k-th largest tracker: sorted cell chain, fill count, result register
`default_nettype none

// Keeps the rank_k largest values of the current set in a chain of MAX_RANK
// cells sorted ascending, so the smallest kept value always sits in cell 0.
// Every cell compares the broadcast sample with its own value and takes its
// own, its neighbor's or the sample in the same cycle, so one item is taken
// per clock; the only stall is a result that waits in the output register
// while out_ready_i is low. The result of an item marked set_end_i is registered
// at its transfer and the chain is then empty for the next set. rank_k is clamped to
// 1..MAX_RANK; the user must write it only while the block is idle, the block itself does not enforce this.
module kth_largest_tracker_unit #(
  parameter int unsigned MAX_RANK = ktt_pkg::MAX_RANK_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [ktt_pkg::RANK_W-1:0]          cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire signed [ktt_pkg::DATA_W-1:0]   sample_value_i,
  input  wire                                set_end_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [ktt_pkg::DATA_W-1:0]  kth_value_o,
  output logic                               set_had_k_o
);
  import ktt_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_RANK + 1);
  localparam int unsigned KW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  logic [RANK_W-1:0]        rank_q;
  logic [CNT_W-1:0]         count_q, count_d, count_after;
  logic [KW-1:0]            k_eff, rank_ext, count_ext, after_ext;
  logic                     in_fire, below_k;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] vals     [MAX_RANK];
  logic signed [DATA_W-1:0] vals_d   [MAX_RANK];
  logic                     gts      [MAX_RANK];
  logic                     lts      [MAX_RANK];
  logic signed [DATA_W-1:0] prev_val [MAX_RANK];
  logic                     prev_gt  [MAX_RANK];
  logic signed [DATA_W-1:0] next_val [MAX_RANK];
  logic                     next_lt  [MAX_RANK];

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] kth_q, kth_d;
  logic                     had_q, had_d;

  // rank register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(1);
    end else if (cfg_valid_i) begin
      rank_q <= cfg_data_i;
    end
  end

  // effective k, clamped to 1..MAX_RANK
  assign rank_ext = KW'(rank_q);

  always_comb begin
    if (rank_q == '0) begin
      k_eff = KW'(1);
    end else if (rank_ext > KW'(MAX_RANK)) begin
      k_eff = KW'(MAX_RANK);
    end else begin
      k_eff = rank_ext;
    end
  end

  // transfer decode and chain command
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_ext  = KW'(count_q);
  assign below_k    = (count_ext < k_eff);

  assign ctrl.add  = in_fire && below_k;
  assign ctrl.repl = in_fire && !below_k && (count_q != '0) && (sample_value_i > vals[0]);

  // sorted chain
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_val[g] = '0;
      assign prev_gt[g]  = 1'b0;
    end else begin : g_mid_lo
      assign prev_val[g] = vals[g-1];
      assign prev_gt[g]  = gts[g-1];
    end
    if (g == MAX_RANK - 1) begin : g_last
      assign next_val[g] = '0;
      assign next_lt[g]  = 1'b0;
    end else begin : g_mid_hi
      assign next_val[g] = vals[g+1];
      assign next_lt[g]  = lts[g+1];
    end

    ktt_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .sample_i     (sample_value_i),
      .prev_value_i (prev_val[g]),
      .prev_gt_i    (prev_gt[g]),
      .next_value_i (next_val[g]),
      .next_lt_i    (next_lt[g]),
      .value_o      (vals[g]),
      .value_d_o    (vals_d[g]),
      .gt_o         (gts[g]),
      .lt_o         (lts[g])
    );
  end

  // fill level, cleared after the last value of a set
  assign count_after = ctrl.add ? (count_q + CNT_W'(1)) : count_q;
  assign after_ext   = KW'(count_after);

  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      count_d = set_end_i ? '0 : count_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    kth_d       = kth_q;
    had_d       = had_q;
    if (in_fire && set_end_i) begin
      out_valid_d = 1'b1;
      kth_d       = vals_d[0];
      had_d       = (after_ext >= k_eff);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kth_q <= kth_d;
    had_q <= had_d;
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign set_had_k_o = had_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= KW'(MAX_RANK))
    else $error("fill level beyond chain depth");

  a_set_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && set_end_i) |=> (count_q == '0) && out_valid_q)
    else $error("set end did not clear the chain or raise a result");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !set_end_i && below_k) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not advance the fill level");

  if (MAX_RANK > 1) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q >= CNT_W'(2)) |-> (vals[0] <= vals[1]))
      else $error("smallest kept value is not at the chain head");
  end

endmodule

`default_nettype wire
